// ===== hw/rtl/chacha20_keystream_block_macros.svh =====
// Assertion helpers used by the keystream block RTL.
`ifndef CHACHA20_KEYSTREAM_BLOCK_MACROS_SVH
`define CHACHA20_KEYSTREAM_BLOCK_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define CC20KS_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cc20ks assertion failed (same cycle)");

// Next-cycle implication, off while reset is high.
`define CC20KS_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cc20ks assertion failed (next cycle)");

`endif

// ===== hw/rtl/cc20ks_pkg.sv =====
package cc20ks_pkg;

  localparam int WORD_W  = 32;
  localparam int NWORDS  = 16;
  localparam int ADDR_W  = 6;
  localparam int DATA_W  = 64;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [NWORDS-1:0][WORD_W-1:0] blk_t;

  // one slot of the round chain
  typedef struct packed {
    logic  vld;
    word_t ctr;
    blk_t  w;
  } cell_t;

  localparam word_t SIGMA0 = 32'h6170_7865;
  localparam word_t SIGMA1 = 32'h3320_646e;
  localparam word_t SIGMA2 = 32'h7962_2d32;
  localparam word_t SIGMA3 = 32'h6b20_6574;

  localparam logic [2:0] PH_LAST   = 3'd7;
  localparam logic [2:0] LAST_PAIR = 3'd7;
  localparam int         CTR_WORD  = 12;

  typedef enum logic [2:0] {
    REG_KEY0     = 3'd0,
    REG_KEY1     = 3'd1,
    REG_KEY2     = 3'd2,
    REG_KEY3     = 3'd3,
    REG_NONCE_LO = 3'd4,
    REG_NONCE_HI = 3'd5
  } reg_idx_t;

  function automatic word_t rotl(word_t v, int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  // One add/xor/rotate step of the quarter round, applied to all four lanes.
  // ph[2] picks column (0) or diagonal (1) lanes, ph[1:0] the step.
  function automatic blk_t qr_step(blk_t w, logic [2:0] ph);
    blk_t       r;
    logic [3:0] ia;
    logic [3:0] ib;
    logic [3:0] ic;
    logic [3:0] id;
    r = w;
    for (int l = 0; l < 4; l++) begin
      ia = {2'b00, 2'(l)};
      ib = {2'b01, ph[2] ? 2'(l + 1) : 2'(l)};
      ic = {2'b10, ph[2] ? 2'(l + 2) : 2'(l)};
      id = {2'b11, ph[2] ? 2'(l + 3) : 2'(l)};
      case (ph[1:0])
        2'd0: begin
          r[ia] = r[ia] + r[ib];
          r[id] = rotl(r[id] ^ r[ia], 16);
        end
        2'd1: begin
          r[ic] = r[ic] + r[id];
          r[ib] = rotl(r[ib] ^ r[ic], 12);
        end
        2'd2: begin
          r[ia] = r[ia] + r[ib];
          r[id] = rotl(r[id] ^ r[ia], 8);
        end
        2'd3: begin
          r[ic] = r[ic] + r[id];
          r[ib] = rotl(r[ib] ^ r[ic], 7);
        end
        default: ;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/cc20ks_in_if.sv =====
interface cc20ks_in_if;
  import cc20ks_pkg::*;

  logic  valid;
  logic  ready;
  word_t block_counter;

  modport source (output valid, output block_counter, input ready);
  modport sink (input valid, input block_counter, output ready);
endinterface

// ===== hw/rtl/cc20ks_out_if.sv =====
interface cc20ks_out_if;
  import cc20ks_pkg::*;

  logic                valid;
  logic                ready;
  logic [DATA_W-1:0]   keystream_pair;
  logic [2:0]          pair_index;
  logic                last_pair;

  modport source (output valid, output keystream_pair, output pair_index,
                  output last_pair, input ready);
  modport sink (input valid, input keystream_pair, input pair_index,
                input last_pair, output ready);
endinterface

// ===== hw/rtl/cc20ks_cell.sv =====
// One double round, one quarter-round step per cycle while en is high, over eight phases.
module cc20ks_cell (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              load,
  input  logic [2:0]        ph,
  input  cc20ks_pkg::cell_t prev,
  output cc20ks_pkg::cell_t res
);
  import cc20ks_pkg::*;

  logic  vld;
  word_t ctr;
  blk_t  w;

  assign res.vld = vld;
  assign res.ctr = ctr;
  assign res.w   = qr_step(w, ph);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (en && load) begin
      vld <= prev.vld;
    end
  end

  // on load take the neighbor's finished state, else keep stepping
  always_ff @(posedge clk) begin
    if (en) begin
      if (load) begin
        ctr <= prev.ctr;
        w   <= prev.w;
      end else begin
        w <= res.w;
      end
    end
  end
endmodule

// ===== hw/rtl/cc20ks_obuf.sv =====
// Final feed-forward add and 8-beat serializer.
module cc20ks_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  cc20ks_pkg::cell_t fin,
  input  cc20ks_pkg::blk_t  init,
  output logic              free,
  cc20ks_out_if.source      ks
);
  import cc20ks_pkg::*;

  blk_t       data;
  blk_t       base;
  logic       full;
  logic [2:0] idx;
  logic       beat;
  logic       done;

  always_comb begin
    base           = init;
    base[CTR_WORD] = fin.ctr;
  end

  assign beat = full && ks.ready;
  assign done = beat && (idx == LAST_PAIR);
  assign free = !full || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      full <= 1'b1;
      idx  <= '0;
    end else if (beat) begin
      full <= !done;
      idx  <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < NWORDS; i++) begin
        data[i] <= fin.w[i] + base[i];
      end
    end
  end

  assign ks.valid          = full;
  assign ks.keystream_pair = {data[{idx, 1'b1}], data[{idx, 1'b0}]};
  assign ks.pair_index     = idx;
  assign ks.last_pair      = (idx == LAST_PAIR);
endmodule

// ===== hw/rtl/chacha20_keystream_block.sv =====
// Path: a counter beat waits in the holding slot for a phase boundary, then
//   passes through the DR cells of the chain, one double round per cell; the
//   output stage registers the feed-forward sum and sends eight pairs.
// Flow: the holding slot takes a new counter while earlier blocks are still
//   in the chain; each cell steps through 8 phases, each block leaves as 8 beats.
// Reset: synchronous, active high; clears key/nonce registers and all valids.
`include "chacha20_keystream_block_macros.svh"

module chacha20_keystream_block #(
  parameter int ROUND_COUNT = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  // APB-style config port, 64-bit registers at 8-byte strides
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cc20ks_pkg::ADDR_W-1:0] paddr,
  input  logic [cc20ks_pkg::DATA_W-1:0] pwdata,
  output logic [cc20ks_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  cc20ks_in_if.sink                     blk_in,
  cc20ks_out_if.source                  ks_out
);
  import cc20ks_pkg::*;

  // Odd round counts round up to a whole double round.
  localparam int DR = (ROUND_COUNT + 1) / 2;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [DATA_W-1:0] key0;
  logic [DATA_W-1:0] key1;
  logic [DATA_W-1:0] key2;
  logic [DATA_W-1:0] key3;
  logic [DATA_W-1:0] nonce_lo;
  word_t             nonce_hi;
  logic              wr;
  logic [2:0]        ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign ridx   = paddr[ADDR_W-1:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      key0     <= '0;
      key1     <= '0;
      key2     <= '0;
      key3     <= '0;
      nonce_lo <= '0;
      nonce_hi <= '0;
    end else if (wr) begin
      case (ridx)
        REG_KEY0:     key0     <= pwdata;
        REG_KEY1:     key1     <= pwdata;
        REG_KEY2:     key2     <= pwdata;
        REG_KEY3:     key3     <= pwdata;
        REG_NONCE_LO: nonce_lo <= pwdata;
        REG_NONCE_HI: nonce_hi <= pwdata[WORD_W-1:0];
        default: ;   // unmapped address: write dropped
      endcase
    end
  end

  always_comb begin
    case (ridx)
      REG_KEY0:     prdata = key0;
      REG_KEY1:     prdata = key1;
      REG_KEY2:     prdata = key2;
      REG_KEY3:     prdata = key3;
      REG_NONCE_LO: prdata = nonce_lo;
      REG_NONCE_HI: prdata = {{(DATA_W - WORD_W){1'b0}}, nonce_hi};
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Input holding slot: a counter beat is taken any time the slot is free
  // and moves into the first cell at the next phase boundary.
  // ---------------------------------------------------------------------
  logic       hold_vld;
  word_t      hold_ctr;
  logic [2:0] ph;
  logic       boundary;
  logic       en;
  logic       take;
  logic       in_beat;

  assign boundary     = (ph == PH_LAST);
  assign take         = en && boundary;
  assign blk_in.ready = !hold_vld || take;
  assign in_beat      = blk_in.valid && blk_in.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_vld <= 1'b0;
    end else if (in_beat) begin
      hold_vld <= 1'b1;
    end else if (take) begin
      hold_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      hold_ctr <= blk_in.block_counter;
    end
  end

  // Starting state. Word 12 carries the held counter for the first cell;
  // the output stage swaps in the counter that traveled with the block.
  blk_t init;

  always_comb begin
    init[0]        = SIGMA0;
    init[1]        = SIGMA1;
    init[2]        = SIGMA2;
    init[3]        = SIGMA3;
    init[4]        = key0[WORD_W-1:0];
    init[5]        = key0[DATA_W-1:WORD_W];
    init[6]        = key1[WORD_W-1:0];
    init[7]        = key1[DATA_W-1:WORD_W];
    init[8]        = key2[WORD_W-1:0];
    init[9]        = key2[DATA_W-1:WORD_W];
    init[10]       = key3[WORD_W-1:0];
    init[11]       = key3[DATA_W-1:WORD_W];
    init[CTR_WORD] = hold_ctr;
    init[13]       = nonce_lo[WORD_W-1:0];
    init[14]       = nonce_lo[DATA_W-1:WORD_W];
    init[15]       = nonce_hi;
  end

  // ---------------------------------------------------------------------
  // Cell chain. All cells share one phase counter: phases 0-3 are the
  // column steps, 4-7 the diagonal steps. In the last phase every cell
  // hands its finished double round to its neighbor, so up to DR blocks
  // are in flight. The chain freezes only when the last cell holds a
  // finished block and the output stage is still sending the one before.
  // ---------------------------------------------------------------------
  cell_t prev [DR];
  cell_t res  [DR];
  logic  ob_free;
  logic  ob_load;

  assign en      = !(boundary && res[DR-1].vld && !ob_free);
  assign ob_load = take && res[DR-1].vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph <= '0;
    end else if (en) begin
      ph <= ph + 3'd1;
    end
  end

  assign prev[0].vld = hold_vld;
  assign prev[0].ctr = hold_ctr;
  assign prev[0].w   = init;

  for (genvar i = 0; i < DR; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign prev[i] = res[i-1];
    end
    cc20ks_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (en),
      .load (boundary),
      .ph   (ph),
      .prev (prev[i]),
      .res  (res[i])
    );
  end

  // ---------------------------------------------------------------------
  // Output: feed-forward add, then eight pair beats
  // ---------------------------------------------------------------------
  cc20ks_obuf u_obuf (
    .clk  (clk),
    .rst  (rst),
    .load (ob_load),
    .fin  (res[DR-1]),
    .init (init),
    .free (ob_free),
    .ks   (ks_out)
  );

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  // a held counter stays put until the chain takes it
  `CC20KS_ASSERT_NEXT(a_hold_keeps, clk, rst, hold_vld && !take,
                      hold_vld && $stable(hold_ctr))
  // phase advances by one whenever the chain runs
  `CC20KS_ASSERT_NEXT(a_phase_step, clk, rst, en, ph == $past(ph) + 3'd1)
  // first cell's valid follows the holding slot on a hand-off
  `CC20KS_ASSERT_NEXT(a_cell0_load, clk, rst, take, res[0].vld == $past(hold_vld))
  // a finished block always lands in the output stage, never dropped
  `CC20KS_ASSERT_NEXT(a_no_drop, clk, rst, ob_load, !ob_free && ks_out.pair_index == 3'd0)
endmodule

// ===== sim/tb_chacha20_keystream_block.sv =====
module tb_chacha20_keystream_block;
  import cc20ks_pkg::*;

  localparam int ROUNDS      = 20;    // rounds per block, matches the dut parameter
  localparam int REG_COUNT   = 6;     // registers decoded by the dut
  localparam int REG_STRIDE  = 8;     // 64-bit registers sit on 8-byte strides
  localparam int SETTLE      = 16;    // quiet cycles before touching config
  localparam int DRAIN       = 120;   // slot wait + round chain + 8 out beats
  localparam int LONG_HOLD   = 400;   // receiver back-pressure stretch
  localparam int WDOG_LIMIT  = 4000;  // cycles with no beat on either side

  // "expand 32-byte k", little-endian words
  localparam word_t EXPAND_0 = 32'h6170_7865;
  localparam word_t EXPAND_1 = 32'h3320_646e;
  localparam word_t EXPAND_2 = 32'h7962_2d32;
  localparam word_t EXPAND_3 = 32'h6b20_6574;

  typedef struct {
    logic [63:0] pair;
    logic [2:0]  idx;
    logic        is_last;
  } ks_beat_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  cc20ks_in_if  ctr_bus ();
  cc20ks_out_if ks_bus ();

  chacha20_keystream_block #(
    .ROUND_COUNT(ROUNDS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .blk_in (ctr_bus),
    .ks_out (ks_bus)
  );

  // Shadow of the key/nonce registers, nonce_high kept masked to 32 bits.
  logic [63:0] cfg_shadow [REG_COUNT];

  word_t    counters_to_send [$];  // counters waiting for the driver
  ks_beat_t keystream_due [$];     // predicted pairs, oldest first

  int counters_queued;
  int counters_accepted;
  int pairs_checked;
  int reg_writes;
  int phases_run;
  int errors;
  int idle_cycles;

  bit tx_idle_on;    // sender inserts random gaps
  bit rx_idle_on;    // receiver inserts random stalls
  int tx_gap;
  int rx_stall;
  int hold_request;  // set by the sequencer, consumed by the receiver

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor: one ChaCha20 block from the shadow config and the counter
  // ---------------------------------------------------------------------------

  function automatic word_t rol32(input word_t v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic blk_t quarter_round(input blk_t s, input int a, input int b,
                                         input int c, input int d);
    blk_t t;
    t = s;
    t[a] = t[a] + t[b]; t[d] = rol32(t[d] ^ t[a], 16);
    t[c] = t[c] + t[d]; t[b] = rol32(t[b] ^ t[c], 12);
    t[a] = t[a] + t[b]; t[d] = rol32(t[d] ^ t[a], 8);
    t[c] = t[c] + t[d]; t[b] = rol32(t[b] ^ t[c], 7);
    return t;
  endfunction

  function automatic blk_t chacha_block(input word_t ctr);
    blk_t init_s;
    blk_t s;
    init_s[0] = EXPAND_0;
    init_s[1] = EXPAND_1;
    init_s[2] = EXPAND_2;
    init_s[3] = EXPAND_3;
    for (int k = 0; k < 4; k++) begin
      init_s[4 + 2*k] = cfg_shadow[REG_KEY0 + k][31:0];
      init_s[5 + 2*k] = cfg_shadow[REG_KEY0 + k][63:32];
    end
    init_s[12] = ctr;
    init_s[13] = cfg_shadow[REG_NONCE_LO][31:0];
    init_s[14] = cfg_shadow[REG_NONCE_LO][63:32];
    init_s[15] = cfg_shadow[REG_NONCE_HI][31:0];
    s = init_s;
    // an odd count still runs a whole double round at the end
    for (int r = 0; r < ROUNDS; r += 2) begin
      s = quarter_round(s, 0, 4, 8, 12);
      s = quarter_round(s, 1, 5, 9, 13);
      s = quarter_round(s, 2, 6, 10, 14);
      s = quarter_round(s, 3, 7, 11, 15);
      s = quarter_round(s, 0, 5, 10, 15);
      s = quarter_round(s, 1, 6, 11, 12);
      s = quarter_round(s, 2, 7, 8, 13);
      s = quarter_round(s, 3, 4, 9, 14);
    end
    for (int i = 0; i < NWORDS; i++) s[i] = s[i] + init_s[i];
    return s;
  endfunction

  function automatic void predict_pairs(input word_t ctr);
    blk_t     w;
    ks_beat_t b;
    w = chacha_block(ctr);
    for (int k = 0; k < 8; k++) begin
      b.pair    = {w[2*k + 1], w[2*k]};
      b.idx     = 3'(k);
      b.is_last = (k == 7);
      keystream_due.push_back(b);
    end
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Counter driver: pops the queue, holds the beat until ready
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (rst) begin
      ctr_bus.valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (ctr_bus.valid && ctr_bus.ready) begin
        predict_pairs(ctr_bus.block_counter);
        counters_accepted++;
      end
      if (!ctr_bus.valid || ctr_bus.ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          ctr_bus.valid <= 1'b0;
        end else if (counters_to_send.size() != 0) begin
          ctr_bus.valid         <= 1'b1;
          ctr_bus.block_counter <= counters_to_send.pop_front();
          if (tx_idle_on) tx_gap = idle_len();
        end else begin
          ctr_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Keystream monitor: checks each beat, drives ready with random stalls
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    ks_beat_t want;
    if (rst) begin
      ks_bus.ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (ks_bus.valid && ks_bus.ready) begin
        pairs_checked++;
        if (keystream_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected keystream beat pair=%h idx=%0d last=%0b", $time,
                   ks_bus.keystream_pair, ks_bus.pair_index, ks_bus.last_pair);
        end else begin
          want = keystream_due.pop_front();
          if (ks_bus.keystream_pair !== want.pair || ks_bus.pair_index !== want.idx ||
              ks_bus.last_pair !== want.is_last) begin
            errors++;
            $display("%0t: mismatch exp pair=%h idx=%0d last=%0b got pair=%h idx=%0d last=%0b",
                     $time, want.pair, want.idx, want.is_last,
                     ks_bus.keystream_pair, ks_bus.pair_index, ks_bus.last_pair);
          end
        end
      end
      if (hold_request > 0) begin
        rx_stall     = hold_request;
        hold_request = 0;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        ks_bus.ready <= 1'b0;
      end else begin
        ks_bus.ready <= 1'b1;
        if (rx_idle_on) rx_stall = idle_len();
      end
    end
  end

  // Watchdog: a long run of cycles with no beat on either channel is a hang.
  always @(posedge clk) begin
    if (!rst) begin
      if ((ctr_bus.valid && ctr_bus.ready) || (ks_bus.valid && ks_bus.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles", $time, idle_cycles);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Config port: setup cycle, then access cycle; write lands on the access edge
  // ---------------------------------------------------------------------------

  task automatic reg_write(input int idx, input logic [63:0] val);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'(idx * REG_STRIDE);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= a;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    // out-of-range indexes decode to nothing
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3, REG_NONCE_LO: cfg_shadow[idx] = val;
      REG_NONCE_HI: cfg_shadow[idx] = {32'h0, val[31:0]};
      default: ;
    endcase
  endtask

  task automatic reg_readback(input int idx);
    logic [ADDR_W-1:0] a;
    logic [63:0]       got;
    a = ADDR_W'(idx * REG_STRIDE);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= a;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (got !== cfg_shadow[idx]) begin
      errors++;
      $display("%0t: register %0d readback exp=%h got=%h", $time, idx, cfg_shadow[idx], got);
    end
  endtask

  task automatic readback_all();
    for (int r = REG_KEY0; r <= REG_NONCE_HI; r++) reg_readback(r);
  endtask

  function automatic logic [63:0] rand_cfg();
    case ($urandom_range(0, 7))
      0: return 64'h0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic load_random_config();
    for (int r = REG_KEY0; r <= REG_NONCE_HI; r++) reg_write(r, rand_cfg());
    // stray writes above the map must not disturb anything
    if ($urandom_range(0, 1)) reg_write($urandom_range(REG_COUNT, REG_COUNT + 1), rand_cfg());
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic send_counter(input word_t c);
    counters_to_send.push_back(c);
    counters_queued++;
  endtask

  // Mostly runs of consecutive counters, as a stream cipher uses them,
  // with edge values and lone random counters mixed in.
  task automatic queue_random_counters(input int n);
    word_t base;
    int    run;
    int    left;
    left = n;
    while (left > 0) begin
      case ($urandom_range(0, 9))
        0: base = 32'h0;
        1: base = 32'hffff_fff0 + $urandom_range(0, 15);  // walks across the wrap
        2: base = $urandom_range(0, 15);
        default: base = $urandom;
      endcase
      run = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 16);
      if (run > left) run = left;
      for (int k = 0; k < run; k++) send_counter(base + k);
      left -= run;
    end
  endtask

  // Block until every counter is in and every pair is out.
  task automatic wait_drained();
    while (counters_accepted != counters_queued || keystream_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    phases_run++;
  endtask

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------

  initial begin
    rst                   = 1'b1;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    for (int r = 0; r < REG_COUNT; r++) cfg_shadow[r] = 64'h0;
    counters_queued   = 0;
    counters_accepted = 0;
    pairs_checked     = 0;
    reg_writes        = 0;
    phases_run        = 0;
    errors            = 0;
    idle_cycles       = 0;
    hold_request      = 0;
    tx_idle_on        = 1'b1;
    rx_idle_on        = 1'b1;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // All-zero key and nonce straight out of reset; counter edges and patterns.
    readback_all();
    send_counter(32'h0000_0000);
    send_counter(32'h0000_0001);
    send_counter(32'hffff_ffff);
    send_counter(32'h8000_0000);
    send_counter(32'h7fff_ffff);
    send_counter(32'h5555_5555);
    send_counter(32'haaaa_aaaa);
    wait_drained();

    // Standard test key 00..1f with nonce 00:00:00:09:00:00:00:4a:00:00:00:00.
    reg_write(REG_KEY0, 64'h0706_0504_0302_0100);
    reg_write(REG_KEY1, 64'h0f0e_0d0c_0b0a_0908);
    reg_write(REG_KEY2, 64'h1716_1514_1312_1110);
    reg_write(REG_KEY3, 64'h1f1e_1d1c_1b1a_1918);
    reg_write(REG_NONCE_LO, 64'h4a00_0000_0900_0000);
    reg_write(REG_NONCE_HI, 64'h0);
    readback_all();
    send_counter(32'h0000_0001);
    send_counter(32'h0000_0000);
    send_counter(32'hffff_ffff);
    wait_drained();

    // All-ones key and nonce; nonce_high is fed 64 ones and must keep 32.
    // Writes above the map are dropped.
    for (int r = REG_KEY0; r <= REG_NONCE_LO; r++) reg_write(r, '1);
    reg_write(REG_NONCE_HI, '1);
    reg_write(REG_COUNT, 64'h0123_4567_89ab_cdef);
    reg_write(REG_COUNT + 1, 64'hfedc_ba98_7654_3210);
    readback_all();
    send_counter(32'h0000_0000);
    send_counter(32'hffff_ffff);
    send_counter(32'hffff_fffe);
    send_counter(32'h0000_0001);
    send_counter(32'hdead_beef);
    wait_drained();

    // Random phases, fresh config each time.
    //   phase 1: no gaps on either side, full rate
    //   phase 3: sender streams while the receiver holds off, filling the block
    for (int p = 0; p < 6; p++) begin
      load_random_config();
      readback_all();
      tx_idle_on = (p != 1) && (p != 3);
      rx_idle_on = (p != 1);
      queue_random_counters(80);
      if (p == 3) hold_request = LONG_HOLD;
      wait_drained();
    end

    repeat (DRAIN) @(posedge clk);
    if (keystream_due.size() != 0) begin
      errors++;
      $display("%0t: %0d keystream pairs never arrived", $time, keystream_due.size());
    end

    $display("Ran %0d block counters over %0d config phases, %0d register writes.",
             counters_accepted, phases_run, reg_writes);
    $display("Compared %0d keystream pairs, with idle, full-rate and long back-pressure runs.",
             pairs_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
